// File: hdl/aabb_overlap_query_table_unit_assert.svh
// Assertion macros shared by the box overlap query table RTL.
`ifndef AABB_OVERLAP_QUERY_TABLE_UNIT_ASSERT_SVH
`define AABB_OVERLAP_QUERY_TABLE_UNIT_ASSERT_SVH

// Condition must hold at every clock edge outside reset.
`define AOQT_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define AOQT_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// File: hdl/aoqt_pkg.sv
// Shared types and constants for the box overlap query table.
`default_nettype none

package aoqt_pkg;

   localparam int OP_W        = 3;
   localparam int ID_W        = 6;
   localparam int FIELD_W     = 32;
   localparam int X_A_LSB     = OP_W;
   localparam int Y_A_LSB     = X_A_LSB + FIELD_W;
   localparam int X_B_LSB     = Y_A_LSB + FIELD_W;
   localparam int Y_B_LSB     = X_B_LSB + FIELD_W;
   localparam int REQ_TDATA_W = 136;
   localparam int RSP_TDATA_W = 8;
   localparam int MAX_HITS    = 64;
   localparam int HIT_CNT_W   = 7;

   typedef enum logic [OP_W-1:0] {
      OP_ADD_ZONE    = 3'd0,
      OP_ADD_SEGMENT = 3'd1,
      OP_BUILD       = 3'd2,
      OP_QUERY_ZONE  = 3'd3,
      OP_QUERY_SEG   = 3'd4
   } opcode_type;

   // Per-ring control: write one cell, or rotate the whole ring by one.
   typedef struct packed {
      logic load;
      logic shift;
   } ring_ctl_type;

endpackage

`default_nettype wire

// File: hdl/aabb_overlap_query_table_unit.sv
// Top level: two box tables held in cell rings, with add, build and overlap query.
//
//  channel | dir | tdata (lsb first)                         | tuser | tlast
//  req_    | in  | opcode[2:0] x_a y_a x_b y_b (32b each)    | -     | -
//  rsp_    | out | status[0] entry_id[6:1]                   | hit   | last
//
//  Add, build and unused opcodes: ST_IDLE accepts, ST_FINISH sends the reply.
//  Query: ST_IDLE accepts; ST_SCAN rotates the queried ring through its depth,
//  one box per cycle set by the single comparator at the head; ST_FINISH replies.
//  The ring rotates only when the output register can take a reply, so a
//  stalled rsp_ side freezes the scan; one hit is held back to mark tlast.
//  Synchronous active-high reset clears counts and control; boxes are not reset.
`default_nettype none

module aabb_overlap_query_table_unit #(
   parameter int MAX_ZONES    = 64,
   parameter int MAX_SEGMENTS = 64,
   parameter int COORD_WIDTH  = 32
) (
   input  wire                                clock,
   input  wire                                reset,
   // opcode, x_a, y_a, x_b, y_b from bit 0 up, zero padded
   input  wire [aoqt_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // status, entry_id from bit 0 up, zero padded
   output logic [aoqt_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                               rsp_tuser,   // hit
   output logic                               rsp_tlast,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready
);

   localparam int CW      = COORD_WIDTH;
   localparam int BOX_W   = 4 * CW;
   localparam int ZCNT_W  = $clog2(MAX_ZONES + 1);
   localparam int SCNT_W  = $clog2(MAX_SEGMENTS + 1);
   localparam int ZIDX_W  = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   localparam int SIDX_W  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
   localparam int MAXC    = (MAX_ZONES > MAX_SEGMENTS) ? MAX_ZONES : MAX_SEGMENTS;
   localparam int SCAN_W  = $clog2(MAXC + 1);
   localparam int ID_W    = aoqt_pkg::ID_W;
   localparam int HC_W    = aoqt_pkg::HIT_CNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // ---------------- registers ----------------
   state_type          state_ff, state_in;
   logic [ZCNT_W-1:0]  zone_count_ff, zone_count_in;
   logic [SCNT_W-1:0]  seg_count_ff, seg_count_in;
   logic [ZCNT_W-1:0]  built_zone_ff, built_zone_in;
   logic [SCNT_W-1:0]  built_seg_ff, built_seg_in;
   logic [BOX_W-1:0]   q_box_ff, q_box_in;
   logic               q_seg_ff, q_seg_in;
   logic [SCAN_W-1:0]  scan_idx_ff, scan_idx_in;
   logic [HC_W-1:0]    hit_cnt_ff, hit_cnt_in;
   // held-back reply, so the last one can carry tlast
   logic               pend_valid_ff, pend_valid_in;
   logic               pend_status_ff, pend_status_in;
   logic [ID_W-1:0]    pend_id_ff, pend_id_in;
   logic               pend_hit_ff, pend_hit_in;
   // output register
   logic               out_valid_ff, out_valid_in;
   logic               out_status_ff, out_status_in;
   logic [ID_W-1:0]    out_id_ff, out_id_in;
   logic               out_hit_ff, out_hit_in;
   logic               out_last_ff, out_last_in;

   // ---------------- request decode ----------------
   logic                   req_fire;
   aoqt_pkg::opcode_type   opcode;
   logic signed [CW-1:0]   x_a, y_a, x_b, y_b;
   logic signed [CW-1:0]   lo_x, hi_x, lo_y, hi_y;
   logic [BOX_W-1:0]       new_box;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign opcode     = aoqt_pkg::opcode_type'(req_tdata[aoqt_pkg::OP_W-1:0]);
   assign x_a        = $signed(req_tdata[aoqt_pkg::X_A_LSB +: CW]);
   assign y_a        = $signed(req_tdata[aoqt_pkg::Y_A_LSB +: CW]);
   assign x_b        = $signed(req_tdata[aoqt_pkg::X_B_LSB +: CW]);
   assign y_b        = $signed(req_tdata[aoqt_pkg::Y_B_LSB +: CW]);
   assign lo_x       = (x_a < x_b) ? x_a : x_b;
   assign hi_x       = (x_a < x_b) ? x_b : x_a;
   assign lo_y       = (y_a < y_b) ? y_a : y_b;
   assign hi_y       = (y_a < y_b) ? y_b : y_a;
   // box layout, lsb first: lo_x, lo_y, hi_x, hi_y
   assign new_box    = {hi_y, hi_x, lo_y, lo_x};

   // ids for add replies: low 6 bits of the count
   logic [ZCNT_W+ID_W-1:0] zone_id_ext;
   logic [SCNT_W+ID_W-1:0] seg_id_ext;
   logic [SCAN_W+ID_W-1:0] scan_id_ext;
   logic                   zone_full, seg_full;

   assign zone_id_ext = (ZCNT_W + ID_W)'(zone_count_ff);
   assign seg_id_ext  = (SCNT_W + ID_W)'(seg_count_ff);
   assign scan_id_ext = (SCAN_W + ID_W)'(scan_idx_ff);
   assign zone_full   = (zone_count_ff == ZCNT_W'(MAX_ZONES));
   assign seg_full    = (seg_count_ff == SCNT_W'(MAX_SEGMENTS));

   // ---------------- box rings ----------------
   aoqt_pkg::ring_ctl_type zone_ctl, seg_ctl;
   logic [BOX_W-1:0]       zone_head, seg_head;

   aoqt_ring #(
      .DEPTH (MAX_ZONES),
      .BOX_W (BOX_W),
      .IDX_W (ZIDX_W)
   ) u_zone_ring (
      .clock    (clock),
      .ctl      (zone_ctl),
      .load_idx (zone_count_ff[ZIDX_W-1:0]),
      .load_box (new_box),
      .head_box (zone_head)
   );

   aoqt_ring #(
      .DEPTH (MAX_SEGMENTS),
      .BOX_W (BOX_W),
      .IDX_W (SIDX_W)
   ) u_seg_ring (
      .clock    (clock),
      .ctl      (seg_ctl),
      .load_idx (seg_count_ff[SIDX_W-1:0]),
      .load_box (new_box),
      .head_box (seg_head)
   );

   // ---------------- head compare ----------------
   logic [BOX_W-1:0]     head;
   logic signed [CW-1:0] h_lo_x, h_lo_y, h_hi_x, h_hi_y;
   logic signed [CW-1:0] q_lo_x, q_lo_y, q_hi_x, q_hi_y;
   logic                 overlap, scan_hit, out_free;
   logic [SCAN_W-1:0]    n_sel, cap_last;

   assign head   = q_seg_ff ? seg_head : zone_head;
   assign h_lo_x = $signed(head[0 +: CW]);
   assign h_lo_y = $signed(head[CW +: CW]);
   assign h_hi_x = $signed(head[2*CW +: CW]);
   assign h_hi_y = $signed(head[3*CW +: CW]);
   assign q_lo_x = $signed(q_box_ff[0 +: CW]);
   assign q_lo_y = $signed(q_box_ff[CW +: CW]);
   assign q_hi_x = $signed(q_box_ff[2*CW +: CW]);
   assign q_hi_y = $signed(q_box_ff[3*CW +: CW]);

   // touching edges count as overlap
   assign overlap  = (h_lo_x <= q_hi_x) && (q_lo_x <= h_hi_x) &&
                     (h_lo_y <= q_hi_y) && (q_lo_y <= h_hi_y);
   assign n_sel    = q_seg_ff ? SCAN_W'(built_seg_ff) : SCAN_W'(built_zone_ff);
   assign cap_last = q_seg_ff ? SCAN_W'(MAX_SEGMENTS - 1) : SCAN_W'(MAX_ZONES - 1);
   assign scan_hit = overlap && (scan_idx_ff < n_sel) &&
                     (hit_cnt_ff < HC_W'(aoqt_pkg::MAX_HITS));
   assign out_free = !out_valid_ff || rsp_tready;

   // ---------------- next state ----------------
   always_comb begin
      state_in       = state_ff;
      zone_count_in  = zone_count_ff;
      seg_count_in   = seg_count_ff;
      built_zone_in  = built_zone_ff;
      built_seg_in   = built_seg_ff;
      q_box_in       = q_box_ff;
      q_seg_in       = q_seg_ff;
      scan_idx_in    = scan_idx_ff;
      hit_cnt_in     = hit_cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_status_in = pend_status_ff;
      pend_id_in     = pend_id_ff;
      pend_hit_in    = pend_hit_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_status_in  = out_status_ff;
      out_id_in      = out_id_ff;
      out_hit_in     = out_hit_ff;
      out_last_in    = out_last_ff;
      zone_ctl       = '0;
      seg_ctl        = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               pend_valid_in = 1'b0;
               state_in      = ST_FINISH;
               case (opcode)
                  aoqt_pkg::OP_ADD_ZONE: begin
                     pend_valid_in = 1'b1;
                     if (zone_full) begin
                        pend_status_in = 1'b1;
                        pend_id_in     = '0;
                        pend_hit_in    = 1'b0;
                     end else begin
                        zone_ctl.load  = 1'b1;
                        zone_count_in  = zone_count_ff + 1'b1;
                        pend_status_in = 1'b0;
                        pend_id_in     = zone_id_ext[ID_W-1:0];
                        pend_hit_in    = 1'b1;
                     end
                  end
                  aoqt_pkg::OP_ADD_SEGMENT: begin
                     pend_valid_in = 1'b1;
                     if (seg_full) begin
                        pend_status_in = 1'b1;
                        pend_id_in     = '0;
                        pend_hit_in    = 1'b0;
                     end else begin
                        seg_ctl.load   = 1'b1;
                        seg_count_in   = seg_count_ff + 1'b1;
                        pend_status_in = 1'b0;
                        pend_id_in     = seg_id_ext[ID_W-1:0];
                        pend_hit_in    = 1'b1;
                     end
                  end
                  aoqt_pkg::OP_BUILD: begin
                     built_zone_in = zone_count_ff;
                     built_seg_in  = seg_count_ff;
                  end
                  aoqt_pkg::OP_QUERY_ZONE, aoqt_pkg::OP_QUERY_SEG: begin
                     q_box_in    = new_box;
                     q_seg_in    = (opcode == aoqt_pkg::OP_QUERY_SEG);
                     scan_idx_in = '0;
                     hit_cnt_in  = '0;
                     state_in    = ST_SCAN;
                  end
                  default: begin
                     // unused opcode: plain no-hit reply
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               zone_ctl.shift = !q_seg_ff;
               seg_ctl.shift  = q_seg_ff;
               scan_idx_in    = scan_idx_ff + 1'b1;
               if (scan_hit) begin
                  if (pend_valid_ff) begin
                     out_valid_in  = 1'b1;
                     out_status_in = pend_status_ff;
                     out_id_in     = pend_id_ff;
                     out_hit_in    = pend_hit_ff;
                     out_last_in   = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_status_in = 1'b0;
                  pend_id_in     = scan_id_ext[ID_W-1:0];
                  pend_hit_in    = 1'b1;
                  hit_cnt_in     = hit_cnt_ff + 1'b1;
               end
               if (scan_idx_ff == cap_last) begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_status_in = pend_valid_ff && pend_status_ff;
               out_id_in     = pend_valid_ff ? pend_id_ff : '0;
               out_hit_in    = pend_valid_ff && pend_hit_ff;
               out_last_in   = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // ---------------- state and registered outputs ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         zone_count_ff <= '0;
         seg_count_ff  <= '0;
         built_zone_ff <= '0;
         built_seg_ff  <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         scan_idx_ff   <= '0;
         hit_cnt_ff    <= '0;
         q_seg_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         zone_count_ff <= zone_count_in;
         seg_count_ff  <= seg_count_in;
         built_zone_ff <= built_zone_in;
         built_seg_ff  <= built_seg_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         scan_idx_ff   <= scan_idx_in;
         hit_cnt_ff    <= hit_cnt_in;
         q_seg_ff      <= q_seg_in;
      end
      q_box_ff       <= q_box_in;
      pend_status_ff <= pend_status_in;
      pend_id_ff     <= pend_id_in;
      pend_hit_ff    <= pend_hit_in;
      out_status_ff  <= out_status_in;
      out_id_ff      <= out_id_in;
      out_hit_ff     <= out_hit_in;
      out_last_ff    <= out_last_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = aoqt_pkg::RSP_TDATA_W'({out_id_ff, out_status_ff});
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tlast  = out_last_ff;

   // ---------------- assertions ----------------
`include "aabb_overlap_query_table_unit_assert.svh"

   `AOQT_ASSERT_IMPLY(a_mid_reply_is_hit, rsp_tvalid && !rsp_tlast, rsp_tuser, "non-final reply without hit")
   `AOQT_ASSERT_ALWAYS(a_built_zone_le_count, built_zone_ff <= zone_count_ff, "built zones exceed added")
   `AOQT_ASSERT_ALWAYS(a_built_seg_le_count, built_seg_ff <= seg_count_ff, "built segments exceed added")
   `AOQT_ASSERT_IMPLY(a_scan_in_range, state_ff == ST_SCAN, scan_idx_ff <= cap_last, "scan index past table")
   `AOQT_ASSERT_ALWAYS(a_hit_cnt_bound, hit_cnt_ff <= HC_W'(aoqt_pkg::MAX_HITS), "too many hits recorded")

endmodule

`default_nettype wire

// File: hdl/aoqt_cell.sv
// One storage cell of the box ring: holds one box, loads or takes its neighbor's box.
`default_nettype none

module aoqt_cell #(
   parameter int BOX_W = 128
) (
   input  wire                       clock,
   input  wire aoqt_pkg::ring_ctl_type ctl,
   input  wire                       sel,
   input  wire [BOX_W-1:0]           load_box,
   input  wire [BOX_W-1:0]           shift_box,
   output logic [BOX_W-1:0]          box
);

   logic [BOX_W-1:0] box_ff;
   logic [BOX_W-1:0] box_in;

   always_comb begin
      box_in = box_ff;
      if (ctl.shift) begin
         box_in = shift_box;
      end else if (ctl.load && sel) begin
         box_in = load_box;
      end
   end

   always_ff @(posedge clock) begin
      box_ff <= box_in;
   end

   assign box = box_ff;

endmodule

`default_nettype wire

// File: hdl/aoqt_ring.sv
// Rotating ring of box cells; cell 0 is the head seen by the comparator.
`default_nettype none

module aoqt_ring #(
   parameter int DEPTH = 64,
   parameter int BOX_W = 128,
   parameter int IDX_W = 6
) (
   input  wire                       clock,
   input  wire aoqt_pkg::ring_ctl_type ctl,
   input  wire [IDX_W-1:0]           load_idx,
   input  wire [BOX_W-1:0]           load_box,
   output logic [BOX_W-1:0]          head_box
);

   logic [BOX_W-1:0] box_q [DEPTH];

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         localparam int NEXT = (g + 1) % DEPTH;
         aoqt_cell #(
            .BOX_W (BOX_W)
         ) u_cell (
            .clock     (clock),
            .ctl       (ctl),
            .sel       (load_idx == IDX_W'(g)),
            .load_box  (load_box),
            .shift_box (box_q[NEXT]),
            .box       (box_q[g])
         );
      end
   endgenerate

   // After k rotations the head holds entry k; DEPTH rotations realign.
   assign head_box = box_q[0];

endmodule

`default_nettype wire
